[src/sos_pkg.sv]
package sos_pkg;

	// Field widths fixed by the interface
	localparam int CNT_W     = 6;   // entry_count register
	localparam int IDX_W     = 5;   // entry_index and hit_index fields
	localparam int EXT_W     = 12;  // extent field, unsigned Q8.4
	localparam int IN_POS_W  = 16;  // pos_x / pos_y fields, signed Q12.4
	localparam int RAD_W     = EXT_W + 1;   // sum of two radii
	localparam int SQ_W      = 2 * RAD_W;   // squared radius / distance

	// Item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Shape kinds
	localparam logic KIND_SQUARE = 1'b0;
	localparam logic KIND_CIRCLE = 1'b1;

	typedef enum logic [1:0] {
		STS_WRITE = 2'd0,
		STS_NOHIT = 2'd1,
		STS_HIT   = 2'd2,
		STS_BAD   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QREAD,
		S_SCAN,
		S_DRAIN,
		S_RESP
	} state_t;

	// Tag that travels with an entry through the compare pipeline
	typedef struct packed {
		logic             vld;
		logic [CNT_W-1:0] idx;
	} tag_t;

endpackage

[src/shape_overlap_scan_top.sv]
// Shape table with a first-hit overlap scan.
// Input channel (in_valid/in_ready) carries one transaction per item: mode 0
// writes an entry (pos_x, pos_y, extent, kind) at entry_index, mode 1 queries
// entry_index against entries 0 .. count-1 in order, skipping itself.
// Output channel (out_valid/out_ready) returns status and hit_index, one
// transaction per input item, in order. cfg_wr_en/cfg_wr_data set entry_count;
// write it only while the block is idle.
// A write or a bad query index passes from acceptance to the pending result
// register and then to the output register. A query reads its own entry, then
// one table entry per cycle from the table RAM; results come out of a 3-stage
// compare pipeline, and the first hit stops the scan. A miss is reported once
// the scan and the pipeline have drained. A new item is accepted only after
// the last one's result has been loaded into the output register.
// One item is in flight at a time.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver only holds the following result back.
// Reset clears entry_count and the control state; table contents are not
// cleared and are undefined until written.
module shape_overlap_scan_top #(
	parameter int MAX_ENTRIES = 32,
	parameter int COORD_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [sos_pkg::IDX_W-1:0]         entry_index,
	input  logic signed [sos_pkg::IN_POS_W-1:0] pos_x,
	input  logic signed [sos_pkg::IN_POS_W-1:0] pos_y,
	input  logic [sos_pkg::EXT_W-1:0]         extent,
	input  logic                              kind,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [sos_pkg::IDX_W-1:0]         hit_index,
	input  logic                              cfg_wr_en,
	input  logic [sos_pkg::CNT_W-1:0]         cfg_wr_data
);

	localparam int ADDR_W = $clog2(MAX_ENTRIES);

	typedef struct packed {
		logic                         kind;
		logic [sos_pkg::EXT_W-1:0]    ext;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] x;
	} shape_t;

	shape_t shape_mem [MAX_ENTRIES];

	sos_pkg::state_t  state_q, state_d;
	sos_pkg::status_t res_status_q, out_status_q;
	logic [sos_pkg::CNT_W-1:0] entry_count_q, count_eff;
	logic [sos_pkg::CNT_W-1:0] scan_q, res_idx_q, out_hit_q;
	logic [sos_pkg::IDX_W-1:0] qidx_q;
	shape_t        query_q, rd_s1, wr_ent;
	sos_pkg::tag_t tag_s1, hit;
	logic          busy;
	logic          accept, bad_idx, mem_we, rd_en, issue, flush, done_nohit, out_load;
	logic [ADDR_W-1:0] rd_addr, wr_addr;

	// Effective count saturates at the table depth
	always_comb begin
		if (32'(entry_count_q) > MAX_ENTRIES) begin
			count_eff = sos_pkg::CNT_W'(MAX_ENTRIES);
		end else begin
			count_eff = entry_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// Control FSM: next state and strobes
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		issue      = 1'b0;
		flush      = 1'b0;
		done_nohit = 1'b0;
		out_load   = 1'b0;
		accept     = 1'b0;
		bad_idx    = ({1'b0, entry_index} >= count_eff);
		unique case (state_q)
			sos_pkg::S_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					if (mode == sos_pkg::MODE_WRITE || bad_idx) begin
						state_d = sos_pkg::S_RESP;
					end else begin
						state_d = sos_pkg::S_QREAD;
					end
				end
			end
			sos_pkg::S_QREAD: begin
				issue   = 1'b1;
				state_d = sos_pkg::S_SCAN;
			end
			sos_pkg::S_SCAN: begin
				if (hit.vld) begin
					flush   = 1'b1;
					state_d = sos_pkg::S_RESP;
				end else if (scan_q < count_eff) begin
					issue = 1'b1;
				end else begin
					state_d = sos_pkg::S_DRAIN;
				end
			end
			sos_pkg::S_DRAIN: begin
				if (hit.vld) begin
					flush   = 1'b1;
					state_d = sos_pkg::S_RESP;
				end else if (!tag_s1.vld && !busy) begin
					done_nohit = 1'b1;
					state_d    = sos_pkg::S_RESP;
				end
			end
			sos_pkg::S_RESP: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = sos_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sos_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sos_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table RAM: one write port, one registered read port
	always_comb begin
		wr_addr     = ADDR_W'(entry_index);
		wr_ent.kind = kind;
		wr_ent.ext  = extent;
		wr_ent.x    = COORD_BITS'(pos_x);
		wr_ent.y    = COORD_BITS'(pos_y);
		mem_we      = accept && (mode == sos_pkg::MODE_WRITE) &&
		              (32'(entry_index) < MAX_ENTRIES);
		rd_en       = (accept && (mode == sos_pkg::MODE_QUERY) && !bad_idx) || issue;
		rd_addr     = (state_q == sos_pkg::S_IDLE) ? ADDR_W'(entry_index) : ADDR_W'(scan_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			shape_mem[wr_addr] <= wr_ent;
		end
		if (rd_en) begin
			rd_s1 <= shape_mem[rd_addr];
		end
	end

	// Scan counter, query index and query shape
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			qidx_q <= '0;
		end else if (accept) begin
			scan_q <= '0;
			qidx_q <= entry_index;
		end else if (issue) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sos_pkg::S_QREAD) begin
			query_q <= rd_s1;
		end
	end

	// Stage 1 tag follows the RAM read; the query's own entry is skipped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.vld <= issue && !flush && (scan_q != {1'b0, qidx_q});
			tag_s1.idx <= scan_q;
		end
	end

	sos_overlap #(
		.COORD_BITS (COORD_BITS)
	) u_overlap (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (flush),
		.tag_in (tag_s1),
		.q_x    (query_q.x),
		.q_y    (query_q.y),
		.q_ext  (query_q.ext),
		.q_kind (query_q.kind),
		.o_x    (rd_s1.x),
		.o_y    (rd_s1.y),
		.o_ext  (rd_s1.ext),
		.o_kind (rd_s1.kind),
		.hit    (hit),
		.busy   (busy)
	);

	// Pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= (mode == sos_pkg::MODE_WRITE) ? sos_pkg::STS_WRITE : sos_pkg::STS_BAD;
			res_idx_q    <= '0;
		end else if (flush) begin
			res_status_q <= sos_pkg::STS_HIT;
			res_idx_q    <= hit.idx;
		end else if (done_nohit) begin
			res_status_q <= sos_pkg::STS_NOHIT;
			res_idx_q    <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_hit_q    <= res_idx_q;
		end
	end

	assign status    = out_status_q;
	assign hit_index = out_hit_q[sos_pkg::IDX_W-1:0];

	// A reported hit lies inside the scanned range
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status_q == sos_pkg::STS_HIT) |-> (out_hit_q < count_eff))
		else $error("hit index outside scanned range");

	// A query never reports itself
	a_hit_not_self: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sos_pkg::S_RESP) && (res_status_q == sos_pkg::STS_HIT)
		|-> (res_idx_q != {1'b0, qidx_q}))
		else $error("query hit its own entry");

	// First hit stops the scan and empties the compare pipeline
	a_hit_flush: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == sos_pkg::S_SCAN) || (state_q == sos_pkg::S_DRAIN)) && hit.vld
		|=> !tag_s1.vld && !busy && (state_q == sos_pkg::S_RESP))
		else $error("scan not stopped after hit");

endmodule

[src/sos_overlap.sv]
// Overlap compare pipeline: query shape against one table entry.
// Stage 2 forms the per-axis gaps and the test radius, stage 3 squares them,
// the hit decision is combinational on the stage 3 registers.
module sos_overlap #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         flush,
	input  sos_pkg::tag_t                tag_in,
	input  logic signed [COORD_BITS-1:0] q_x,
	input  logic signed [COORD_BITS-1:0] q_y,
	input  logic [sos_pkg::EXT_W-1:0]    q_ext,
	input  logic                         q_kind,
	input  logic signed [COORD_BITS-1:0] o_x,
	input  logic signed [COORD_BITS-1:0] o_y,
	input  logic [sos_pkg::EXT_W-1:0]    o_ext,
	input  logic                         o_kind,
	output sos_pkg::tag_t                hit,
	output logic                         busy
);

	// Wide enough for a coordinate plus an extent, and for any gap
	localparam int WD = ((COORD_BITS > sos_pkg::RAD_W) ? COORD_BITS : sos_pkg::RAD_W) + 2;
	localparam int SUM_W = sos_pkg::SQ_W + 1;

	logic signed [WD-1:0] qx, qy, qhx, qhy, ox, oy, ohx, ohy;
	logic signed [WD-1:0] cx, cy, lox, loy, hix, hiy;
	logic [WD-1:0]        adx, ady;
	logic [sos_pkg::RAD_W-1:0] rad;
	logic                 c_is_q, cc, circ, ss;

	logic [WD-1:0]             adx_s2, ady_s2;
	logic [sos_pkg::RAD_W-1:0] rad_s2;
	logic                      ss_s2, circ_s2;
	sos_pkg::tag_t             tag_s2;

	logic [sos_pkg::RAD_W-1:0] ax, ay;
	logic                      rej;

	logic [sos_pkg::SQ_W-1:0]  dx2_s3, dy2_s3, r2_s3;
	logic                      rej_s3, ss_s3, circ_s3;
	sos_pkg::tag_t             tag_s3;

	logic [SUM_W-1:0]          dsum;
	logic                      hit_c;

	// Gap geometry. A circle-circle test is a circle against a point box at
	// the other centre, with the radii summed.
	always_comb begin
		qx  = WD'(q_x);
		qy  = WD'(q_y);
		ox  = WD'(o_x);
		oy  = WD'(o_y);
		qhx = qx + $signed(WD'(q_ext));
		qhy = qy + $signed(WD'(q_ext));
		ohx = ox + $signed(WD'(o_ext));
		ohy = oy + $signed(WD'(o_ext));

		ss = (ox <= qhx) && (qx <= ohx) && (oy <= qhy) && (qy <= ohy);

		c_is_q = (q_kind == sos_pkg::KIND_CIRCLE);
		cc     = (q_kind == sos_pkg::KIND_CIRCLE) && (o_kind == sos_pkg::KIND_CIRCLE);
		circ   = (q_kind == sos_pkg::KIND_CIRCLE) || (o_kind == sos_pkg::KIND_CIRCLE);

		cx  = c_is_q ? qx : ox;
		cy  = c_is_q ? qy : oy;
		lox = c_is_q ? ox : qx;
		loy = c_is_q ? oy : qy;
		hix = cc ? lox : (c_is_q ? ohx : qhx);
		hiy = cc ? loy : (c_is_q ? ohy : qhy);

		if (cx < lox) begin
			adx = $unsigned(lox - cx);
		end else if (cx > hix) begin
			adx = $unsigned(cx - hix);
		end else begin
			adx = '0;
		end
		if (cy < loy) begin
			ady = $unsigned(loy - cy);
		end else if (cy > hiy) begin
			ady = $unsigned(cy - hiy);
		end else begin
			ady = '0;
		end

		if (cc) begin
			rad = sos_pkg::RAD_W'(q_ext) + sos_pkg::RAD_W'(o_ext);
		end else begin
			rad = sos_pkg::RAD_W'(c_is_q ? q_ext : o_ext);
		end
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (flush) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		adx_s2  <= adx;
		ady_s2  <= ady;
		rad_s2  <= rad;
		ss_s2   <= ss;
		circ_s2 <= circ;
	end

	// Early reject keeps the squares narrow
	always_comb begin
		rej = (adx_s2 > WD'(rad_s2)) || (ady_s2 > WD'(rad_s2));
		ax  = adx_s2[sos_pkg::RAD_W-1:0];
		ay  = ady_s2[sos_pkg::RAD_W-1:0];
	end

	// Stage 3 registers: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (flush) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx2_s3  <= sos_pkg::SQ_W'(ax) * sos_pkg::SQ_W'(ax);
		dy2_s3  <= sos_pkg::SQ_W'(ay) * sos_pkg::SQ_W'(ay);
		r2_s3   <= sos_pkg::SQ_W'(rad_s2) * sos_pkg::SQ_W'(rad_s2);
		rej_s3  <= rej;
		ss_s3   <= ss_s2;
		circ_s3 <= circ_s2;
	end

	// Hit decision
	always_comb begin
		dsum  = SUM_W'(dx2_s3) + SUM_W'(dy2_s3);
		hit_c = circ_s3 ? (!rej_s3 && (dsum <= SUM_W'(r2_s3))) : ss_s3;
		hit.vld = tag_s3.vld && hit_c;
		hit.idx = tag_s3.idx;
	end

	assign busy = tag_s2.vld || tag_s3.vld;

endmodule

[test/testbench.sv]
module testbench;

	localparam int TABLE_DEPTH = 32;
	localparam int STALL_LIMIT = 4000;  // cycles with no transaction on either side
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		sos_pkg::status_t          st;
		logic [sos_pkg::IDX_W-1:0] hit;
	} outcome_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_ready;
	logic                                mode;
	logic [sos_pkg::IDX_W-1:0]           entry_index;
	logic signed [sos_pkg::IN_POS_W-1:0] pos_x;
	logic signed [sos_pkg::IN_POS_W-1:0] pos_y;
	logic [sos_pkg::EXT_W-1:0]           extent;
	logic                                kind;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [1:0]                          status;
	logic [sos_pkg::IDX_W-1:0]           hit_index;
	logic                                cfg_wr_en;
	logic [sos_pkg::CNT_W-1:0]           cfg_wr_data;

	// Shadow copy of the shape table and the count register
	logic signed [sos_pkg::IN_POS_W-1:0] shadow_x [TABLE_DEPTH];
	logic signed [sos_pkg::IN_POS_W-1:0] shadow_y [TABLE_DEPTH];
	logic [sos_pkg::EXT_W-1:0]           shadow_ext [TABLE_DEPTH];
	logic                                shadow_kind [TABLE_DEPTH];
	logic [sos_pkg::CNT_W-1:0]           shadow_count;

	outcome_t pending_outcomes [$];
	outcome_t got_outcome;
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       quiet_cycles = 0;

	shape_overlap_scan_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.entry_index(entry_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.extent     (extent),
		.kind       (kind),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.hit_index  (hit_index),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Overlap prediction
	// ---------------------------------------------------------------

	// dx^2 + dy^2 <= r^2, early reject keeps the products small
	function automatic bit within_radius(longint dx, longint dy, longint r);
		longint ax, ay;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax > r || ay > r)
			return 1'b0;
		return (ax * ax + ay * ay) <= (r * r);
	endfunction

	// Clamp the centre to the box, then a radius test on the remainder
	function automatic bit circle_box(longint cx, longint cy, longint cr,
					  longint sx, longint sy, longint se);
		longint px, py;
		px = cx;
		py = cy;
		if (px < sx) px = sx; else if (px > sx + se) px = sx + se;
		if (py < sy) py = sy; else if (py > sy + se) py = sy + se;
		return within_radius(cx - px, cy - py, cr);
	endfunction

	function automatic bit shapes_touch(int q, int other);
		longint qx, qy, qe, ox, oy, oe;
		qx = shadow_x[q];
		qy = shadow_y[q];
		qe = shadow_ext[q];
		ox = shadow_x[other];
		oy = shadow_y[other];
		oe = shadow_ext[other];
		if (shadow_kind[q] == sos_pkg::KIND_SQUARE &&
		    shadow_kind[other] == sos_pkg::KIND_SQUARE)
			return ox <= qx + qe && qx <= ox + oe && oy <= qy + qe && qy <= oy + oe;
		if (shadow_kind[q] == sos_pkg::KIND_CIRCLE &&
		    shadow_kind[other] == sos_pkg::KIND_CIRCLE)
			return within_radius(qx - ox, qy - oy, qe + oe);
		if (shadow_kind[q] == sos_pkg::KIND_CIRCLE)
			return circle_box(qx, qy, qe, ox, oy, oe);
		return circle_box(ox, oy, oe, qx, qy, qe);
	endfunction

	function automatic int scan_span();
		return (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
	endfunction

	// Write updates the shadow table; query finds the first overlap
	function automatic outcome_t predict_outcome(logic m, logic [sos_pkg::IDX_W-1:0] idx,
			logic signed [sos_pkg::IN_POS_W-1:0] x,
			logic signed [sos_pkg::IN_POS_W-1:0] y,
			logic [sos_pkg::EXT_W-1:0] e, logic k);
		outcome_t o;
		int span;
		o.st = sos_pkg::STS_WRITE;
		o.hit = '0;
		if (m == sos_pkg::MODE_WRITE) begin
			shadow_x[idx] = x;
			shadow_y[idx] = y;
			shadow_ext[idx] = e;
			shadow_kind[idx] = k;
			return o;
		end
		span = scan_span();
		if (idx >= span) begin
			o.st = sos_pkg::STS_BAD;
			return o;
		end
		o.st = sos_pkg::STS_NOHIT;
		for (int i = 0; i < span; i++) begin
			if (i != idx && shapes_touch(idx, i)) begin
				o.st = sos_pkg::STS_HIT;
				o.hit = i[sos_pkg::IDX_W-1:0];
				return o;
			end
		end
		return o;
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result transaction with no item outstanding");
			end else begin
				got_outcome = pending_outcomes.pop_front();
				if (status !== got_outcome.st)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, got_outcome.st));
				if (hit_index !== got_outcome.hit)
					report_mismatch($sformatf("hit_index %0d, predicted %0d",
						hit_index, got_outcome.hit));
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog on handshake progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Present one transaction; valid is left high after acceptance
	task automatic send_item(logic m, logic [sos_pkg::IDX_W-1:0] idx,
			logic signed [sos_pkg::IN_POS_W-1:0] x,
			logic signed [sos_pkg::IN_POS_W-1:0] y,
			logic [sos_pkg::EXT_W-1:0] e, logic k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		entry_index <= idx;
		pos_x <= x;
		pos_y <= y;
		extent <= e;
		kind <= k;
		do @(posedge clk); while (!in_ready);
		pending_outcomes.push_back(predict_outcome(m, idx, x, y, e, k));
	endtask

	// Stop sending and wait until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_entry_count(logic [sos_pkg::CNT_W-1:0] n);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_count = n;
	endtask

	task automatic query(logic [sos_pkg::IDX_W-1:0] idx);
		send_item(sos_pkg::MODE_QUERY, idx, 16'($urandom), 16'($urandom), 12'($urandom),
			1'($urandom));
	endtask

	function automatic logic signed [sos_pkg::IN_POS_W-1:0] rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 85)
			return sos_pkg::IN_POS_W'(int'($urandom_range(1023)) - 512);
		if (r < 90)
			return (r & 1) ? 16'sh7FFF : 16'sh8000;
		return sos_pkg::IN_POS_W'($urandom);
	endfunction

	function automatic logic [sos_pkg::EXT_W-1:0] rand_extent();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return sos_pkg::EXT_W'($urandom_range(200));
		if (r < 90)
			return sos_pkg::EXT_W'($urandom_range(1023));
		return sos_pkg::EXT_W'($urandom_range(4095));
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Fill the whole table so no scan ever reads an unwritten entry
	task automatic test_preload();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_item(sos_pkg::MODE_WRITE, i[sos_pkg::IDX_W-1:0],
				sos_pkg::IN_POS_W'(-32768 + i * 1024),
				sos_pkg::IN_POS_W'(-32768 + i * 1024), '0, i[0]);
		// extremes: big box at the low corner, big circle at the high corner
		send_item(sos_pkg::MODE_WRITE, 5'd0, 16'sh8000, 16'sh8000, 12'hFFF,
			sos_pkg::KIND_SQUARE);
		send_item(sos_pkg::MODE_WRITE, 5'd31, 16'sh7FFF, 16'sh7FFF, 12'hFFF,
			sos_pkg::KIND_CIRCLE);
	endtask

	// Count of zero, one, full table and saturation beyond it
	task automatic test_count_limits();
		set_entry_count(6'd0);
		query(5'd0);
		query(5'd31);
		set_entry_count(6'd63);
		query(5'd31);
		query(5'd0);
		set_entry_count(6'd33);
		query(5'd31);
		set_entry_count(6'd32);
		query(5'd1);
		set_entry_count(6'd1);
		query(5'd0);   // only entry is itself
		query(5'd1);   // index at count
	endtask

	// Inclusive edges and exact-distance contacts for each kind pairing
	task automatic test_shape_pairs();
		set_entry_count(6'd8);
		send_item(sos_pkg::MODE_WRITE, 5'd0, 16'sd0, 16'sd0, 12'd16, sos_pkg::KIND_SQUARE);
		// gap of one
		send_item(sos_pkg::MODE_WRITE, 5'd1, 16'sd17, 16'sd0, 12'd16, sos_pkg::KIND_SQUARE);
		// corner touch
		send_item(sos_pkg::MODE_WRITE, 5'd2, 16'sd16, 16'sd16, 12'd16, sos_pkg::KIND_SQUARE);
		query(5'd0);
		query(5'd1);
		send_item(sos_pkg::MODE_WRITE, 5'd3, 16'sd64, 16'sd64, 12'd0, sos_pkg::KIND_CIRCLE);
		// 3-4-5 contact
		send_item(sos_pkg::MODE_WRITE, 5'd4, 16'sd112, 16'sd128, 12'd80, sos_pkg::KIND_CIRCLE);
		query(5'd3);
		query(5'd4);
		// edge contact
		send_item(sos_pkg::MODE_WRITE, 5'd5, 16'sd192, 16'sd128, 12'd10, sos_pkg::KIND_SQUARE);
		query(5'd5);
		// just outside
		send_item(sos_pkg::MODE_WRITE, 5'd5, 16'sd193, 16'sd128, 12'd10, sos_pkg::KIND_SQUARE);
		query(5'd5);
		send_item(sos_pkg::MODE_WRITE, 5'd6, 16'sh8000, 16'sh8000, 12'hFFF,
			sos_pkg::KIND_SQUARE);
		send_item(sos_pkg::MODE_WRITE, 5'd7, 16'sh7FFF, 16'sh7FFF, 12'hFFF,
			sos_pkg::KIND_CIRCLE);
		query(5'd6);
		query(5'd7);
	endtask

	task automatic run_random(int n, int send_pct, int recv_pct,
			logic [sos_pkg::CNT_W-1:0] count);
		int span;
		logic [sos_pkg::IDX_W-1:0] idx;
		set_entry_count(count);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		span = scan_span();
		for (int i = 0; i < n; i++) begin
			if (span > 0 && $urandom_range(99) < 80)
				idx = sos_pkg::IDX_W'($urandom_range(span - 1));
			else
				idx = sos_pkg::IDX_W'($urandom);
			if ($urandom_range(99) < 40)
				send_item(sos_pkg::MODE_WRITE, idx, rand_coord(), rand_coord(),
					rand_extent(), 1'($urandom));
			else
				query(idx);
			// occasionally hold off until the block has emptied
			if (i % 64 == 63)
				drain_results();
		end
	endtask

	task automatic test_random_traffic();
		run_random(200, 0, 0, 6'd32);
		run_random(200, 67, 0, 6'd12);
		run_random(200, 0, 67, 6'd63);
		run_random(200, 22, 22, 6'd5);
		run_random(100, 0, 0, 6'd1);
		run_random(200, 22, 22, 6'd20);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = sos_pkg::MODE_WRITE;
		entry_index = '0;
		pos_x = '0;
		pos_y = '0;
		extent = '0;
		kind = sos_pkg::KIND_SQUARE;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		shadow_count = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_preload();
		test_count_limits();
		test_shape_pairs();
		test_random_traffic();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
